// ===== src/pwmpd_pkg.sv =====
// Shared constants, register indexes and bus types for the PWM phase/duty generator.
`default_nettype none

package pwmpd_pkg;

  // Field widths
  localparam int DIVIDER_BITS  = 27;
  localparam int FRACTION_BITS = 16;
  localparam int RES_BITS      = 4;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  // Largest period is 2^(2^RES_BITS) * 2^DIVIDER_BITS
  localparam int CNT_BITS  = (1 << RES_BITS) + DIVIDER_BITS;
  localparam int PER_BITS  = CNT_BITS + 1;
  localparam int DIVP_BITS = DIVIDER_BITS + 1;
  localparam int PROD_BITS = FRACTION_BITS + DIVP_BITS;
  localparam int SH_BITS   = PROD_BITS + (1 << RES_BITS);
  localparam int SHAMT_BITS = RES_BITS + 1;
  localparam int STEP_CNT_BITS = $clog2(CNT_BITS);

  // Reset values of the configuration registers
  localparam logic [RES_BITS-1:0]     RESET_RESOLUTION = RES_BITS'(7);
  localparam logic [DIVIDER_BITS-1:0] RESET_DIVIDER    = DIVIDER_BITS'(32768);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_COUNT_ENABLE   = 3'd0,
    REG_RESOLUTION     = 3'd1,
    REG_CLOCK_DIVIDER  = 3'd2,
    REG_CHANNEL_ENABLE = 3'd3,
    REG_INVERT_OUTPUT  = 3'd4,
    REG_DUTY_FRACTION  = 3'd5,
    REG_PHASE_FRACTION = 3'd6
  } reg_idx_t;

  // Controller to datapath commands
  typedef struct packed {
    logic calc1;      // period and fraction products
    logic calc2;      // duty and phase counts
    logic calc3;      // derived thresholds
    logic take_item;  // capture the tick of an accepted word
    logic load_cnt;   // base <= counter (counter already in range)
    logic mod_start;  // start counter mod period
    logic mod_step;   // one remainder step
    logic load_rem;   // base <= remainder
    logic adv;        // advance counter when tick is set
    logic sum;        // shifted position before wrap
    logic out_load;   // load the result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic enabled;
    logic cnt_in_range;
  } sts_t;

endpackage

`default_nettype wire

// ===== src/pwmpd_if.sv =====
// Channel interfaces: step input, result output and configuration write.
`default_nettype none

interface pwmpd_step_if;
  logic valid;
  logic ready;
  logic tick;
  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

interface pwmpd_result_if;
  logic                          valid;
  logic                          ready;
  logic                          pwm_level;
  logic [pwmpd_pkg::CNT_BITS-1:0] count_now;
  modport source (output valid, output pwm_level, output count_now, input ready);
  modport sink   (input valid, input pwm_level, input count_now, output ready);
endinterface

interface pwmpd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [pwmpd_pkg::CFG_IDX_BITS-1:0]  index;
  logic [pwmpd_pkg::CFG_DATA_BITS-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/pwm_phase_duty_generator_core.sv =====
// Top level of the single-channel PWM generator with phase delay.
//
// Channels: step (sink) takes one word per time step, its tick bit set when a
// clock of the PWM elapses; result (source) returns one word per step with the
// channel level and the period counter after that step; cfg (sink) writes the
// seven registers by index and is always ready.
// Each word passes the states CHECK, ADV, SUM and FIN when enabled and the
// counter is within the period, or CHECK and FIN when disabled; result valid
// is registered from FIN. When a register change has left the counter at or
// above the new period, the remainder unit adds its MOD steps and MLOAD before
// ADV. One word is in work at a time, so the next word is taken only after FIN.
// After reset and after every register write, the period and the duty and
// phase thresholds are recomputed in CALC1 to CALC3, when step is not ready.
// Reset loads the register defaults and clears the counter.
// A finished result waits in the output register while the next word is
// taken; if result is stalled, that next word waits in its last step.
`default_nettype none

module pwm_phase_duty_generator_core (
  input wire logic         clk,
  input wire logic         rst,
  pwmpd_step_if.sink       step,
  pwmpd_result_if.source   result,
  pwmpd_cfg_if.sink        cfg
);

  pwmpd_pkg::cmd_t cmd;
  pwmpd_pkg::sts_t sts;
  logic            cfg_we;

  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid;

  pwmpd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .step_valid (step.valid),
    .step_ready (step.ready),
    .cfg_we     (cfg_we),
    .out_ready  (result.ready),
    .out_valid  (result.valid),
    .cmd        (cmd),
    .sts        (sts)
  );

  pwmpd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .step_tick (step.tick),
    .cfg_we    (cfg_we),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .pwm_level (result.pwm_level),
    .count_now (result.count_now)
  );

endmodule

`default_nettype wire

// ===== src/pwmpd_rem.sv =====
// Restoring remainder unit: counter mod period, one dividend bit per step.
`default_nettype none

module pwmpd_rem (
  input  wire logic                           clk,
  input  wire logic                           start,
  input  wire logic                           step,
  input  wire logic [pwmpd_pkg::CNT_BITS-1:0] dividend,
  input  wire logic [pwmpd_pkg::PER_BITS-1:0] divisor,
  output logic      [pwmpd_pkg::CNT_BITS-1:0] remainder
);

  logic [pwmpd_pkg::CNT_BITS-1:0] dvd;
  logic [pwmpd_pkg::PER_BITS-1:0] rem;
  logic [pwmpd_pkg::PER_BITS-1:0] trial;

  // Shift in the next dividend bit; rem stays below divisor so its top bit is clear
  assign trial = {rem[pwmpd_pkg::PER_BITS-2:0], dvd[pwmpd_pkg::CNT_BITS-1]};

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (step) begin
      dvd <= {dvd[pwmpd_pkg::CNT_BITS-2:0], 1'b0};
      rem <= (trial >= divisor) ? trial - divisor : trial;
    end
  end

  assign remainder = rem[pwmpd_pkg::CNT_BITS-1:0];

endmodule

`default_nettype wire

// ===== src/pwmpd_ctrl.sv =====
// Sequencing controller: threshold precompute, item steps and result handoff.
`default_nettype none

module pwmpd_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step_valid,
  output logic                 step_ready,
  input  wire logic            cfg_we,
  input  wire logic            out_ready,
  output logic                 out_valid,
  output pwmpd_pkg::cmd_t      cmd,
  input  wire pwmpd_pkg::sts_t sts
);

  typedef enum logic [9:0] {
    S_CALC1 = 10'b0000000001,
    S_CALC2 = 10'b0000000010,
    S_CALC3 = 10'b0000000100,
    S_IDLE  = 10'b0000001000,
    S_CHECK = 10'b0000010000,
    S_MOD   = 10'b0000100000,
    S_MLOAD = 10'b0001000000,
    S_ADV   = 10'b0010000000,
    S_SUM   = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic [pwmpd_pkg::STEP_CNT_BITS-1:0] mod_cnt;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    step_ready = 1'b0;
    unique case (state)
      S_CALC1: begin
        cmd.calc1  = 1'b1;
        state_next = S_CALC2;
      end
      S_CALC2: begin
        cmd.calc2  = 1'b1;
        state_next = S_CALC3;
      end
      S_CALC3: begin
        cmd.calc3  = 1'b1;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        step_ready = 1'b1;
        if (step_valid) begin
          cmd.take_item = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.enabled) begin
          state_next = S_FIN;
        end else if (sts.cnt_in_range) begin
          cmd.load_cnt = 1'b1;
          state_next   = S_ADV;
        end else begin
          cmd.mod_start = 1'b1;
          state_next    = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (mod_cnt == '0) state_next = S_MLOAD;
      end
      S_MLOAD: begin
        cmd.load_rem = 1'b1;
        state_next   = S_ADV;
      end
      S_ADV: begin
        cmd.adv    = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CALC1;
    endcase
    // A register write invalidates the precomputed thresholds
    if (cfg_we) state_next = S_CALC1;
  end

  // State, step counter and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CALC1;
      out_valid <= 1'b0;
      mod_cnt   <= '0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cmd.mod_start) mod_cnt <= pwmpd_pkg::STEP_CNT_BITS'(pwmpd_pkg::CNT_BITS - 1);
      else if (cmd.mod_step) mod_cnt <= mod_cnt - 1'b1;
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result register overwritten while still held");

  a_mod_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD) && (mod_cnt == '0) && !cfg_we |=> (state == S_MLOAD))
    else $error("remainder sequence did not finish after last step");

  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    step_valid && step_ready && !cfg_we |=> (state == S_CHECK))
    else $error("accepted word not processed");

endmodule

`default_nettype wire

// ===== src/pwmpd_datapath.sv =====
// Datapath: configuration registers, thresholds, period counter and result register.
`default_nettype none

module pwmpd_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire pwmpd_pkg::cmd_t                     cmd,
  output pwmpd_pkg::sts_t                          sts,
  input  wire logic                                step_tick,
  input  wire logic                                cfg_we,
  input  wire logic [pwmpd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [pwmpd_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output logic                                     pwm_level,
  output logic      [pwmpd_pkg::CNT_BITS-1:0]      count_now
);

  // Configuration registers
  logic                                 count_enable;
  logic [pwmpd_pkg::RES_BITS-1:0]       resolution;
  logic [pwmpd_pkg::DIVIDER_BITS-1:0]   clock_divider;
  logic                                 channel_enable;
  logic                                 invert_output;
  logic [pwmpd_pkg::FRACTION_BITS-1:0]  duty_fraction;
  logic [pwmpd_pkg::FRACTION_BITS-1:0]  phase_fraction;

  // Thresholds
  logic [pwmpd_pkg::PER_BITS-1:0]   period;
  logic [pwmpd_pkg::PROD_BITS-1:0]  duty_prod;
  logic [pwmpd_pkg::PROD_BITS-1:0]  phase_prod;
  logic [pwmpd_pkg::PER_BITS-1:0]   duty_cnt;
  logic [pwmpd_pkg::PER_BITS-1:0]   phase_cnt;
  logic [pwmpd_pkg::PER_BITS-1:0]   per_minus_phase;
  logic [pwmpd_pkg::PER_BITS:0]     per_plus_duty;

  // Item state
  logic                             tick_q;
  logic [pwmpd_pkg::CNT_BITS-1:0]   counter;
  logic [pwmpd_pkg::CNT_BITS-1:0]   base;
  logic [pwmpd_pkg::PER_BITS:0]     pos;
  logic [pwmpd_pkg::CNT_BITS-1:0]   rem_out;

  logic [pwmpd_pkg::DIVP_BITS-1:0]  div_p1;
  logic [pwmpd_pkg::SHAMT_BITS-1:0] shamt;
  logic [pwmpd_pkg::SH_BITS-1:0]    duty_sh;
  logic [pwmpd_pkg::SH_BITS-1:0]    phase_sh;
  logic [pwmpd_pkg::PER_BITS-1:0]   base_inc;
  logic                             wrap;
  logic [pwmpd_pkg::CNT_BITS-1:0]   base_next;
  logic                             raw_level;
  logic                             level;

  // Register writes; bits above each width are dropped, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      count_enable   <= 1'b0;
      resolution     <= pwmpd_pkg::RESET_RESOLUTION;
      clock_divider  <= pwmpd_pkg::RESET_DIVIDER;
      channel_enable <= 1'b0;
      invert_output  <= 1'b0;
      duty_fraction  <= '0;
      phase_fraction <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pwmpd_pkg::REG_COUNT_ENABLE:   count_enable <= cfg_data[0];
        pwmpd_pkg::REG_RESOLUTION:
          resolution <= cfg_data[pwmpd_pkg::RES_BITS-1:0];
        pwmpd_pkg::REG_CLOCK_DIVIDER:
          clock_divider <= cfg_data[pwmpd_pkg::DIVIDER_BITS-1:0];
        pwmpd_pkg::REG_CHANNEL_ENABLE: channel_enable <= cfg_data[0];
        pwmpd_pkg::REG_INVERT_OUTPUT:  invert_output  <= cfg_data[0];
        pwmpd_pkg::REG_DUTY_FRACTION:
          duty_fraction <= cfg_data[pwmpd_pkg::FRACTION_BITS-1:0];
        pwmpd_pkg::REG_PHASE_FRACTION:
          phase_fraction <= cfg_data[pwmpd_pkg::FRACTION_BITS-1:0];
        default: ;
      endcase
    end
  end

  // period = (divider+1) << (resolution+1); fraction*period = (fraction*(divider+1)) << shift
  assign div_p1   = {1'b0, clock_divider} + 1'b1;
  assign shamt    = {1'b0, resolution} + 1'b1;
  assign duty_sh  = pwmpd_pkg::SH_BITS'(duty_prod) << shamt;
  assign phase_sh = pwmpd_pkg::SH_BITS'(phase_prod) << shamt;

  always_ff @(posedge clk) begin
    if (cmd.calc1) begin
      period     <= pwmpd_pkg::PER_BITS'(div_p1) << shamt;
      duty_prod  <= pwmpd_pkg::PROD_BITS'(duty_fraction) * pwmpd_pkg::PROD_BITS'(div_p1);
      phase_prod <= pwmpd_pkg::PROD_BITS'(phase_fraction) * pwmpd_pkg::PROD_BITS'(div_p1);
    end
    if (cmd.calc2) begin
      duty_cnt  <= duty_sh[pwmpd_pkg::FRACTION_BITS +: pwmpd_pkg::PER_BITS];
      phase_cnt <= phase_sh[pwmpd_pkg::FRACTION_BITS +: pwmpd_pkg::PER_BITS];
    end
    if (cmd.calc3) begin
      per_minus_phase <= period - phase_cnt;
      per_plus_duty   <= {1'b0, period} + {1'b0, duty_cnt};
    end
  end

  // Counter mod period for a counter left beyond a shortened period
  pwmpd_rem u_rem (
    .clk       (clk),
    .start     (cmd.mod_start),
    .step      (cmd.mod_step),
    .dividend  (counter),
    .divisor   (period),
    .remainder (rem_out)
  );

  // Advance of the in-range counter value
  assign base_inc  = {1'b0, base} + 1'b1;
  assign wrap      = (base_inc == period);
  assign base_next = wrap ? '0 : base_inc[pwmpd_pkg::CNT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
    end else if (cmd.adv && tick_q) begin
      counter <= base_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) tick_q <= step_tick;
    if (cmd.load_cnt) base <= counter;
    else if (cmd.load_rem) base <= rem_out;
    else if (cmd.adv && tick_q) base <= base_next;
    if (cmd.sum) pos <= {1'b0, {1'b0, base} + per_minus_phase};
  end

  // pos is below twice the period; compare against duty on either side of the wrap
  assign raw_level = (pos >= {1'b0, period}) ? (pos < per_plus_duty)
                                             : (pos < {1'b0, duty_cnt});
  assign level = sts.enabled & (raw_level ^ invert_output);

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pwm_level <= level;
      count_now <= counter;
    end
  end

  assign sts.enabled      = count_enable & channel_enable;
  assign sts.cnt_in_range = ({1'b0, counter} < period);

  a_counter_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.adv && tick_q |=> ({1'b0, counter} < period))
    else $error("counter advanced out of period");

  a_base_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.sum |-> ({1'b0, base} < period))
    else $error("shifted position taken from unreduced counter");

  a_thresholds: assert property (@(posedge clk) disable iff (rst)
    cmd.calc3 |-> (duty_cnt < period) && (phase_cnt < period))
    else $error("duty or phase count not below period");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the single-channel PWM generator with phase delay.
`timescale 1ns / 1ps

module testbench;

  localparam int LIMIT = 400000;
  localparam int SETTLE = 60;
  localparam int PHASES = 30;
  localparam logic [pwmpd_pkg::CFG_IDX_BITS-1:0] REG_SPARE = 3'd7;  // unmapped index

  typedef struct packed {
    logic                           level;
    logic [pwmpd_pkg::CNT_BITS-1:0] count;
  } pwm_word_t;

  typedef enum bit {ROW_WRITE, ROW_STEP} row_kind_t;

  typedef struct {
    row_kind_t                           kind;
    logic [pwmpd_pkg::CFG_IDX_BITS-1:0]  idx;
    logic [pwmpd_pkg::CFG_DATA_BITS-1:0] data;
    logic                                tick;
    bit                                  known;
    logic                                level;
    logic [pwmpd_pkg::CNT_BITS-1:0]      count;
  } stim_row_t;

  logic clk;
  logic rst;

  pwmpd_step_if   step_bus();
  pwmpd_result_if result_bus();
  pwmpd_cfg_if    cfg_bus();

  pwm_phase_duty_generator_core uut (
    .clk    (clk),
    .rst    (rst),
    .step   (step_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  // Shadow copy of the channel registers and the period counter
  logic                                en_counter;
  logic [pwmpd_pkg::RES_BITS-1:0]      res_sel;
  logic [pwmpd_pkg::DIVIDER_BITS-1:0]  div_sel;
  logic                                en_channel;
  logic                                inv_sel;
  logic [pwmpd_pkg::FRACTION_BITS-1:0] duty_sel;
  logic [pwmpd_pkg::FRACTION_BITS-1:0] phase_sel;
  logic [pwmpd_pkg::CNT_BITS-1:0]      period_pos;

  pwm_word_t   level_count_q[$];
  pwm_word_t   want;
  stim_row_t   plan[$];
  int          mismatches;
  int          cycle_count;
  bit          steady;

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Advance the shadow counter by one word and return the level and count it gives
  function automatic pwm_word_t advance_channel(input logic t);
    longint unsigned period;
    longint unsigned duty_cnt;
    longint unsigned phase_cnt;
    longint unsigned pos;
    pwm_word_t w;
    w.level = 1'b0;
    if (en_counter && en_channel) begin
      period = (64'd1 << (int'(res_sel) + 1)) * (64'(div_sel) + 64'd1);
      if (t) period_pos = pwmpd_pkg::CNT_BITS'((64'(period_pos) + 64'd1) % period);
      duty_cnt  = (64'(duty_sel) * period) >> pwmpd_pkg::FRACTION_BITS;
      phase_cnt = (64'(phase_sel) * period) >> pwmpd_pkg::FRACTION_BITS;
      pos = (64'(period_pos) + period - phase_cnt) % period;
      w.level = (pos < duty_cnt) ^ inv_sel;
    end
    w.count = period_pos;
    return w;
  endfunction

  // Register write; valid stays high so back-to-back writes need no re-raise
  task automatic write_reg(input logic [pwmpd_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [pwmpd_pkg::CFG_DATA_BITS-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      pwmpd_pkg::REG_COUNT_ENABLE:   en_counter = data[0];
      pwmpd_pkg::REG_RESOLUTION:     res_sel    = data[pwmpd_pkg::RES_BITS-1:0];
      pwmpd_pkg::REG_CLOCK_DIVIDER:  div_sel    = data[pwmpd_pkg::DIVIDER_BITS-1:0];
      pwmpd_pkg::REG_CHANNEL_ENABLE: en_channel = data[0];
      pwmpd_pkg::REG_INVERT_OUTPUT:  inv_sel    = data[0];
      pwmpd_pkg::REG_DUTY_FRACTION:  duty_sel   = data[pwmpd_pkg::FRACTION_BITS-1:0];
      pwmpd_pkg::REG_PHASE_FRACTION: phase_sel  = data[pwmpd_pkg::FRACTION_BITS-1:0];
      default: ;
    endcase
  endtask

  // One step word; the expectation is typed in when known, else predicted
  task automatic send_tick(input logic t, input bit known, input logic lvl,
                           input logic [pwmpd_pkg::CNT_BITS-1:0] cnt);
    pwm_word_t w;
    step_bus.valid <= 1'b1;
    step_bus.tick  <= t;
    do @(posedge clk); while (!step_bus.ready);
    w = advance_channel(t);
    if (known) begin
      w.level = lvl;
      w.count = cnt;
    end
    level_count_q.push_back(w);
    if (!steady && $urandom_range(99) < 20) begin
      step_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Stop sending and wait for every outstanding result word
  task automatic drain_results();
    step_bus.valid <= 1'b0;
    do @(posedge clk); while (level_count_q.size() != 0);
  endtask

  task automatic add_write(input logic [pwmpd_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [pwmpd_pkg::CFG_DATA_BITS-1:0] data);
    stim_row_t r;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.data = data;
    r.tick = 1'b0;
    r.known = 1'b0;
    r.level = 1'b0;
    r.count = '0;
    plan.push_back(r);
  endtask

  task automatic add_step(input logic t, input bit known, input logic lvl,
                          input logic [pwmpd_pkg::CNT_BITS-1:0] cnt);
    stim_row_t r;
    r.kind = ROW_STEP;
    r.idx = '0;
    r.data = '0;
    r.tick = t;
    r.known = known;
    r.level = lvl;
    r.count = cnt;
    plan.push_back(r);
  endtask

  // Result sink with random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= steady || ($urandom_range(99) >= 20);
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (level_count_q.size() == 0) begin
        flag_mismatch("result word with nothing outstanding");
      end else begin
        want = level_count_q.pop_front();
        if (result_bus.pwm_level !== want.level)
          flag_mismatch($sformatf("pwm_level %b, expected %b",
                                  result_bus.pwm_level, want.level));
        if (result_bus.count_now !== want.count)
          flag_mismatch($sformatf("count_now %0d, expected %0d",
                                  result_bus.count_now, want.count));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("pwm_phase_duty_generator_core regression: fail");
      $finish;
    end
  end

  // Stimulus
  initial begin
    logic [31:0] junk;
    int n_items;
    rst <= 1'b1;
    step_bus.valid <= 1'b0;
    step_bus.tick <= 1'b0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= '0;
    cfg_bus.data <= '0;
    steady = 1'b0;
    en_counter = 1'b0;
    res_sel = pwmpd_pkg::RESET_RESOLUTION;
    div_sel = pwmpd_pkg::RESET_DIVIDER;
    en_channel = 1'b0;
    inv_sel = 1'b0;
    duty_sel = '0;
    phase_sel = '0;
    period_pos = '0;

    // Directed table: disabled after reset, excess bits, extremes, wrap,
    // counter left beyond a shrunk period, report without tick, spare index
    add_step(1'b1, 1, 1'b0, '0);
    add_step(1'b0, 1, 1'b0, '0);
    add_write(pwmpd_pkg::REG_COUNT_ENABLE, 32'd1);
    add_step(1'b1, 1, 1'b0, '0);
    add_write(pwmpd_pkg::REG_CHANNEL_ENABLE, 32'd1);
    add_write(pwmpd_pkg::REG_COUNT_ENABLE, 32'd0);
    add_step(1'b1, 1, 1'b0, '0);
    add_write(pwmpd_pkg::REG_COUNT_ENABLE, 32'hFFFF_FFFF);
    add_write(pwmpd_pkg::REG_RESOLUTION, 32'hFFFF_FFF0);
    add_write(pwmpd_pkg::REG_CLOCK_DIVIDER, 32'hF800_0000);
    add_write(pwmpd_pkg::REG_DUTY_FRACTION, 32'hFFFF_8000);
    add_step(1'b1, 0, 1'b0, '0);
    add_step(1'b1, 0, 1'b0, '0);
    add_step(1'b0, 0, 1'b0, '0);
    add_write(pwmpd_pkg::REG_INVERT_OUTPUT, 32'hFFFF_FFFF);
    add_step(1'b1, 0, 1'b0, '0);
    add_write(REG_SPARE, 32'hFFFF_FFFF);
    add_write(pwmpd_pkg::REG_INVERT_OUTPUT, 32'd0);
    add_write(pwmpd_pkg::REG_DUTY_FRACTION, 32'h0000_FFFF);
    add_write(pwmpd_pkg::REG_PHASE_FRACTION, 32'hFFFF_FFFF);
    add_write(pwmpd_pkg::REG_RESOLUTION, 32'd15);
    add_write(pwmpd_pkg::REG_CLOCK_DIVIDER, 32'h07FF_FFFF);
    add_step(1'b1, 0, 1'b0, '0);
    add_step(1'b1, 0, 1'b0, '0);
    add_step(1'b0, 0, 1'b0, '0);
    add_step(1'b1, 0, 1'b0, '0);
    // shrink the period below the counter
    add_write(pwmpd_pkg::REG_RESOLUTION, 32'd0);
    add_write(pwmpd_pkg::REG_CLOCK_DIVIDER, 32'd0);
    add_write(pwmpd_pkg::REG_DUTY_FRACTION, 32'h0000_8000);
    add_write(pwmpd_pkg::REG_PHASE_FRACTION, 32'd0);
    add_step(1'b0, 0, 1'b0, '0);
    add_step(1'b1, 0, 1'b0, '0);
    add_write(pwmpd_pkg::REG_RESOLUTION, 32'd2);
    add_write(pwmpd_pkg::REG_CLOCK_DIVIDER, 32'd1);
    add_write(pwmpd_pkg::REG_PHASE_FRACTION, 32'h0000_4000);
    add_step(1'b1, 0, 1'b0, '0);
    add_step(1'b1, 0, 1'b0, '0);
    add_step(1'b1, 0, 1'b0, '0);
    add_step(1'b1, 0, 1'b0, '0);
    add_step(1'b1, 0, 1'b0, '0);
    // disabled while inverted: level stays low, counter holds
    add_write(pwmpd_pkg::REG_INVERT_OUTPUT, 32'd1);
    add_write(pwmpd_pkg::REG_COUNT_ENABLE, 32'd0);
    add_step(1'b1, 0, 1'b0, '0);
    add_step(1'b0, 0, 1'b0, '0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        if (i == 0 || plan[i-1].kind == ROW_STEP) drain_results();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        if (i > 0 && plan[i-1].kind == ROW_WRITE) cfg_bus.valid <= 1'b0;
        send_tick(plan[i].tick, plan[i].known, plan[i].level, plan[i].count);
      end
    end

    // Random phases: new settings while idle, then a run of steps
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      steady = (p >= 10 && p < 14);
      if ($urandom_range(99) < 40) begin
        junk = ($urandom_range(3) == 0) ? $urandom() : 32'd0;
        write_reg(pwmpd_pkg::REG_COUNT_ENABLE,
                  {junk[31:1], 1'($urandom_range(99) < 88)});
      end
      if ($urandom_range(99) < 50) begin
        junk = ($urandom_range(3) == 0) ? $urandom() : 32'd0;
        write_reg(pwmpd_pkg::REG_RESOLUTION, {junk[31:pwmpd_pkg::RES_BITS],
          pwmpd_pkg::RES_BITS'(($urandom_range(9) < 8) ? $urandom_range(3)
                                                       : $urandom_range(15))});
      end
      if ($urandom_range(99) < 50) begin
        junk = ($urandom_range(3) == 0) ? $urandom() : 32'd0;
        case ($urandom_range(9))
          0:       write_reg(pwmpd_pkg::REG_CLOCK_DIVIDER,
                             {junk[31:pwmpd_pkg::DIVIDER_BITS],
                              {pwmpd_pkg::DIVIDER_BITS{1'b1}}});
          1:       write_reg(pwmpd_pkg::REG_CLOCK_DIVIDER,
                             {junk[31:pwmpd_pkg::DIVIDER_BITS],
                              pwmpd_pkg::DIVIDER_BITS'($urandom())});
          default: write_reg(pwmpd_pkg::REG_CLOCK_DIVIDER,
                             {junk[31:pwmpd_pkg::DIVIDER_BITS],
                              pwmpd_pkg::DIVIDER_BITS'($urandom_range(3))});
        endcase
      end
      if ($urandom_range(99) < 40) begin
        junk = ($urandom_range(3) == 0) ? $urandom() : 32'd0;
        write_reg(pwmpd_pkg::REG_CHANNEL_ENABLE,
                  {junk[31:1], 1'($urandom_range(99) < 88)});
      end
      if ($urandom_range(99) < 40) begin
        junk = ($urandom_range(3) == 0) ? $urandom() : 32'd0;
        write_reg(pwmpd_pkg::REG_INVERT_OUTPUT, {junk[31:1], 1'($urandom_range(1))});
      end
      if ($urandom_range(99) < 60) begin
        junk = ($urandom_range(3) == 0) ? $urandom() : 32'd0;
        case ($urandom_range(9))
          0:       write_reg(pwmpd_pkg::REG_DUTY_FRACTION,
                             {junk[31:pwmpd_pkg::FRACTION_BITS], 16'h0000});
          1:       write_reg(pwmpd_pkg::REG_DUTY_FRACTION,
                             {junk[31:pwmpd_pkg::FRACTION_BITS], 16'hFFFF});
          default: write_reg(pwmpd_pkg::REG_DUTY_FRACTION,
                             {junk[31:pwmpd_pkg::FRACTION_BITS],
                              pwmpd_pkg::FRACTION_BITS'($urandom())});
        endcase
      end
      if ($urandom_range(99) < 60) begin
        junk = ($urandom_range(3) == 0) ? $urandom() : 32'd0;
        case ($urandom_range(9))
          0:       write_reg(pwmpd_pkg::REG_PHASE_FRACTION,
                             {junk[31:pwmpd_pkg::FRACTION_BITS], 16'h0000});
          1:       write_reg(pwmpd_pkg::REG_PHASE_FRACTION,
                             {junk[31:pwmpd_pkg::FRACTION_BITS], 16'hFFFF});
          default: write_reg(pwmpd_pkg::REG_PHASE_FRACTION,
                             {junk[31:pwmpd_pkg::FRACTION_BITS],
                              pwmpd_pkg::FRACTION_BITS'($urandom())});
        endcase
      end
      if ($urandom_range(9) == 0) write_reg(REG_SPARE, $urandom());
      cfg_bus.valid <= 1'b0;

      n_items = $urandom_range(20, 40);
      for (int k = 0; k < n_items; k++)
        send_tick(1'($urandom_range(99) < 85), 1'b0, 1'b0, '0);
    end
    steady = 1'b0;

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("pwm_phase_duty_generator_core regression: pass");
    end else begin
      $display("pwm_phase_duty_generator_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/pwmpd_pkg.sv
src/pwmpd_if.sv
src/pwmpd_rem.sv
src/pwmpd_ctrl.sv
src/pwmpd_datapath.sv
src/pwm_phase_duty_generator_core.sv
tb/testbench.sv
